@@ rtl/core/dlpll_pkg.sv @@
// Shared types, constants and microcode program for the digital linear PLL.
// Used by the datapath, the top level and the port checker; depends on nothing.
package dlpll_pkg;

    // Default parameter values
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 12;

    // Fixed field and arithmetic widths
    localparam int COEF_W          = 16;
    localparam int MUL_A_W         = COEF_W + 1;
    localparam int FILT_W          = 32;
    localparam int PHASE_W         = 32;
    localparam int HALF_W          = 30;
    localparam int LEVEL_W         = 2;
    localparam int DCO_SCALE_SHIFT = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Result stream: filter_out, dco_level, dco_phase_next, padded to bytes
    localparam int M_FIELDS_W = FILT_W + LEVEL_W + PHASE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [COEF_W-1:0] POLE_COEF_RST  = 16'hF05E;  // -4002
    localparam logic [COEF_W-1:0] ZERO_NOW_RST   = 16'd4348;
    localparam logic [COEF_W-1:0] ZERO_PREV_RST  = 16'hF138;  // -3784
    localparam logic [COEF_W-1:0] CENTRE_INC_RST = 16'd628;
    localparam logic [COEF_W-1:0] DCO_GAIN_RST   = 16'd1;
    localparam logic [HALF_W-1:0] HALF_CYCLE_RST = 30'd25133;

    // DCO level codes
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 2'b00;
    localparam logic [LEVEL_W-1:0] LEVEL_POS  = 2'b01;
    localparam logic [LEVEL_W-1:0] LEVEL_NEG  = 2'b11;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_COEF  = 3'd0,
        REG_ZERO_NOW   = 3'd1,
        REG_ZERO_PREV  = 3'd2,
        REG_CENTRE_INC = 3'd3,
        REG_DCO_GAIN   = 3'd4,
        REG_HALF_CYCLE = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] pole_coef;
        logic [COEF_W-1:0] zero_coef_now;
        logic [COEF_W-1:0] zero_coef_prev;
        logic [COEF_W-1:0] centre_increment;
        logic [COEF_W-1:0] dco_gain;
        logic [HALF_W-1:0] half_cycle;
    } cfg_regs_t;

    // Microcode fields
    typedef enum logic [1:0] {
        A_POLE_NEG  = 2'd0,
        A_ZERO_NOW  = 2'd1,
        A_ZERO_PREV = 2'd2,
        A_GAIN      = 2'd3
    } a_sel_t;

    typedef enum logic [1:0] {
        B_PREV_FILT = 2'd0,
        B_DET       = 2'd1,
        B_PREV_DET  = 2'd2,
        B_SCALED    = 2'd3
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic {
        SEQ_NEXT = 1'b0,
        SEQ_DONE = 1'b1
    } seq_op_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        logic    mul_en;
        acc_op_t acc_op;
        logic    sat_en;
        logic    sum_en;
        seq_op_t seq;
    } ctrl_word_t;

    // Control bundle from sequencer to datapath
    typedef struct packed {
        ctrl_word_t uword;
        logic       load;
        logic       commit;
    } dp_ctrl_t;

    localparam int NUM_STEPS = 8;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // Microcode program: one control word per step
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '0;
        unique case (step)
            3'd0: begin
                w.a_sel = A_POLE_NEG;  w.b_sel = B_PREV_FILT; w.mul_en = 1'b1;
            end
            3'd1: begin
                w.a_sel = A_ZERO_NOW;  w.b_sel = B_DET;       w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD;
            end
            3'd2: begin
                w.a_sel = A_ZERO_PREV; w.b_sel = B_PREV_DET;  w.mul_en = 1'b1;
                w.acc_op = ACC_ADD;
            end
            3'd3: w.acc_op = ACC_ADD;
            3'd4: w.sat_en = 1'b1;
            3'd5: begin
                w.a_sel = A_GAIN;      w.b_sel = B_SCALED;    w.mul_en = 1'b1;
            end
            3'd6: w.sum_en = 1'b1;
            3'd7: w.seq = SEQ_DONE;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/dlpll_datapath.sv @@
// Datapath of the digital linear PLL: shared multiplier, accumulator, loop state.
// Driven by control words from the top-level sequencer; depends on dlpll_pkg.
module dlpll_datapath #(
    parameter int SAMPLE_WIDTH   = dlpll_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = dlpll_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  dlpll_pkg::dp_ctrl_t                      ctrl,
    input  dlpll_pkg::cfg_regs_t                     cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]           sample,
    output logic signed [dlpll_pkg::FILT_W-1:0]      filter_out,
    output logic        [dlpll_pkg::LEVEL_W-1:0]     level_out,
    output logic signed [dlpll_pkg::PHASE_W-1:0]     phase_out
);
    import dlpll_pkg::*;

    localparam int DW   = SAMPLE_WIDTH + 1;
    localparam int BW   = (DW > FILT_W) ? DW : FILT_W;
    localparam int PW   = BW + MUL_A_W;
    localparam int AW   = PW + 2;
    localparam int SUMW = PW + 2;
    localparam int HIW  = AW - FILT_W + 1;

    // Loop state
    logic signed [DW-1:0]      prev_det_reg;
    logic signed [FILT_W-1:0]  prev_filt_reg;
    logic signed [PHASE_W-1:0] phase_reg;
    logic [LEVEL_W-1:0]        level_reg;

    // Working registers
    logic signed [DW-1:0]      det_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [SUMW-1:0]    sum_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [BW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_p;
    logic signed [AW-1:0]      acc_shift;
    logic [HIW-1:0]            acc_hi;
    logic signed [FILT_W-1:0]  filt_next;
    logic signed [FILT_W-1:0]  filt_scaled;
    logic signed [PHASE_W-1:0] wrapped;
    logic                      wrap_hit;

    // Select multiplier operands
    always_comb begin
        case (ctrl.uword.a_sel)
            A_POLE_NEG:  mul_a = -$signed({cfg.pole_coef[COEF_W-1], cfg.pole_coef});
            A_ZERO_NOW:  mul_a = $signed({cfg.zero_coef_now[COEF_W-1], cfg.zero_coef_now});
            A_ZERO_PREV: mul_a = $signed({cfg.zero_coef_prev[COEF_W-1], cfg.zero_coef_prev});
            A_GAIN:      mul_a = $signed({cfg.dco_gain[COEF_W-1], cfg.dco_gain});
            default:     mul_a = '0;
        endcase
    end

    assign filt_scaled = filt_reg >>> DCO_SCALE_SHIFT;

    always_comb begin
        case (ctrl.uword.b_sel)
            B_PREV_FILT: mul_b = BW'(prev_filt_reg);
            B_DET:       mul_b = BW'(det_reg);
            B_PREV_DET:  mul_b = BW'(prev_det_reg);
            B_SCALED:    mul_b = BW'(filt_scaled);
            default:     mul_b = '0;
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Shift down and saturate the accumulated filter sum
    assign acc_shift = acc_reg >>> COEF_FRAC_BITS;
    assign acc_hi    = acc_shift[AW-1:FILT_W-1];

    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            filt_next = acc_shift[FILT_W-1:0];
        end else if (acc_shift[AW-1]) begin
            filt_next = {1'b1, {(FILT_W-1){1'b0}}};
        end else begin
            filt_next = {1'b0, {(FILT_W-1){1'b1}}};
        end
    end

    // Wrap the advanced phase once by two half-cycles
    assign wrap_hit = sum_reg > $signed(SUMW'(cfg.half_cycle));
    assign wrapped  = wrap_hit ? sum_reg[PHASE_W-1:0] - {1'b0, cfg.half_cycle, 1'b0}
                               : sum_reg[PHASE_W-1:0];

    // Working registers follow the control word
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            case (level_reg)
                LEVEL_POS: det_reg <= DW'(sample);
                LEVEL_NEG: det_reg <= -DW'(sample);
                default:   det_reg <= '0;
            endcase
        end
        if (ctrl.uword.mul_en) begin
            prod_reg <= mul_p;
        end
        case (ctrl.uword.acc_op)
            ACC_LOAD: acc_reg <= AW'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + AW'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
        if (ctrl.uword.sat_en) begin
            filt_reg <= filt_next;
        end
        if (ctrl.uword.sum_en) begin
            sum_reg <= SUMW'(phase_reg) + $signed(SUMW'(cfg.centre_increment))
                     + SUMW'(prod_reg);
        end
        if (ctrl.commit) begin
            filter_out <= filt_reg;
            level_out  <= level_reg;
            phase_out  <= wrapped;
        end
    end

    // Loop state advances on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_det_reg  <= '0;
            prev_filt_reg <= '0;
            phase_reg     <= '0;
            level_reg     <= LEVEL_ZERO;
        end else if (ctrl.commit) begin
            prev_det_reg  <= det_reg;
            prev_filt_reg <= filt_reg;
            phase_reg     <= wrapped;
            level_reg     <= wrapped[PHASE_W-1] ? LEVEL_NEG : LEVEL_POS;
        end
    end

endmodule

@@ rtl/core/digital_linear_pll_core.sv @@
// Digital linear PLL core: stream ports, configuration registers, microcode sequencer.
// A sample runs through 8 microcode steps (four products on the shared multiplier);
// the last step commits the result and waits while a result is unread. No new sample
// is accepted until the last step has finished.
// Reset (aresetn low, synchronous): loop state cleared, registers to defaults, no result.
// Depends on dlpll_pkg and dlpll_datapath.
module digital_linear_pll_core #(
    parameter int SAMPLE_WIDTH   = dlpll_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = dlpll_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [SAMPLE_WIDTH-1:0] input_sample, zero padding above
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
    // m_tdata: [31:0] filter_out, [33:32] dco_level, [65:34] dco_phase_next, zeros above
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dlpll_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dlpll_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlpll_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dlpll_pkg::*;

    cfg_regs_t           cfg_reg;
    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                m_tvalid_reg;
    ctrl_word_t          uword;
    dp_ctrl_t            dp_ctrl;
    logic                accept;
    logic                out_free;
    logic                commit;
    logic signed [FILT_W-1:0]  filter_out;
    logic        [LEVEL_W-1:0] level_out;
    logic signed [PHASE_W-1:0] phase_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Fetch the current control word; idle issues no operations
    assign uword  = busy_reg ? ucode_rom(step_reg) : '0;
    assign commit = busy_reg && (uword.seq == SEQ_DONE) && out_free;

    assign dp_ctrl.uword  = uword;
    assign dp_ctrl.load   = accept;
    assign dp_ctrl.commit = commit;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pole_coef        <= POLE_COEF_RST;
            cfg_reg.zero_coef_now    <= ZERO_NOW_RST;
            cfg_reg.zero_coef_prev   <= ZERO_PREV_RST;
            cfg_reg.centre_increment <= CENTRE_INC_RST;
            cfg_reg.dco_gain         <= DCO_GAIN_RST;
            cfg_reg.half_cycle       <= HALF_CYCLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POLE_COEF:  cfg_reg.pole_coef        <= cfg_data[COEF_W-1:0];
                REG_ZERO_NOW:   cfg_reg.zero_coef_now    <= cfg_data[COEF_W-1:0];
                REG_ZERO_PREV:  cfg_reg.zero_coef_prev   <= cfg_data[COEF_W-1:0];
                REG_CENTRE_INC: cfg_reg.centre_increment <= cfg_data[COEF_W-1:0];
                REG_DCO_GAIN:   cfg_reg.dco_gain         <= cfg_data[COEF_W-1:0];
                REG_HALF_CYCLE: cfg_reg.half_cycle       <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Step counter: start on accept, advance each step, finish when the result slot frees
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (uword.seq == SEQ_NEXT) begin
                step_reg <= step_reg + 1'b1;
            end else if (out_free) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Result valid: set on commit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    dlpll_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (dp_ctrl),
        .cfg        (cfg_reg),
        .sample     ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .filter_out (filter_out),
        .level_out  (level_out),
        .phase_out  (phase_out)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, phase_out, level_out, filter_out};

endmodule

@@ rtl/core/dlpll_checker.sv @@
// Port-level checks for the digital linear PLL core, bound to the top level.
// Sees only the top-level ports; depends on dlpll_pkg.
module dlpll_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dlpll_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dlpll_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Drop ready after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // Raise a new result only as the engine frees up
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $rose(s_tready))
        else $error("result appeared without finishing a computation");

    // Never report a level outside -1, 0, +1
    a_level_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[FILT_W+LEVEL_W-1:FILT_W] == LEVEL_ZERO ||
                      m_tdata[FILT_W+LEVEL_W-1:FILT_W] == LEVEL_POS ||
                      m_tdata[FILT_W+LEVEL_W-1:FILT_W] == LEVEL_NEG))
        else $error("invalid DCO level code");

    // Come out of reset idle and empty
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind digital_linear_pll_core dlpll_checker u_dlpll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/digital_linear_pll_core_tb.sv @@
// Self-checking bench for digital_linear_pll_core: directed table, then random phases under
// reset or random loop settings; every result is checked against a local loop model or a
// typed table value. Depends on dlpll_pkg and the digital_linear_pll_core RTL.
`timescale 1ns / 100ps

module digital_linear_pll_core_tb;
    import dlpll_pkg::*;

    localparam int  SMP_W           = SAMPLE_WIDTH_DEF;
    localparam int  FRAC_BITS       = COEF_FRAC_BITS_DEF;
    localparam int  CYCLE_LIMIT     = 1000000;
    localparam int  PHASES          = 6;
    localparam int  PHASE_REQUESTS  = 221;
    localparam int  LONG_HOLD       = 400;
    localparam int  MAX_REPORTS     = 10;
    localparam longint FILT_MAX     = 2147483647;
    localparam longint FILT_MIN     = -FILT_MAX - 1;

    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        SET_RESET  = 2'd0,
        SET_HIGH   = 2'd1,
        SET_LOW    = 2'd2,
        SET_RANDOM = 2'd3
    } loop_setting_t;

    typedef struct packed {
        logic [FILT_W-1:0]  filt;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
    } pll_result_t;

    typedef struct packed {
        loop_setting_t     setting;
        logic              typed;
        logic [SMP_W-1:0]  sample;
        pll_result_t       result;
    } dir_row_t;

    localparam pll_result_t UNTYPED = '0;

    // Directed requests; typed results only right after reset
    localparam dir_row_t DIRECTED [24] = '{
        {SET_RESET, 1'b1, 24'h7FFFFF, {32'd0, LEVEL_ZERO, 32'd628}},
        {SET_RESET, 1'b1, 24'h000000, {32'd0, LEVEL_POS, 32'd1256}},
        {SET_RESET, 1'b1, 24'h000000, {32'd0, LEVEL_POS, 32'd1884}},
        {SET_RESET, 1'b0, 24'h7FFFFF, UNTYPED},
        {SET_RESET, 1'b0, 24'h800000, UNTYPED},
        {SET_RESET, 1'b0, 24'hFFFFFF, UNTYPED},
        {SET_RESET, 1'b0, 24'h000001, UNTYPED},
        {SET_RESET, 1'b0, 24'h555555, UNTYPED},
        {SET_RESET, 1'b0, 24'hAAAAAA, UNTYPED},
        {SET_RESET, 1'b0, 24'h7FFFFF, UNTYPED},
        {SET_RESET, 1'b0, 24'h800000, UNTYPED},
        {SET_HIGH,  1'b0, 24'h7FFFFF, UNTYPED},
        {SET_HIGH,  1'b0, 24'h7FFFFF, UNTYPED},
        {SET_HIGH,  1'b0, 24'h800000, UNTYPED},
        {SET_HIGH,  1'b0, 24'h7FFFFF, UNTYPED},
        {SET_HIGH,  1'b0, 24'h800000, UNTYPED},
        {SET_HIGH,  1'b0, 24'h000000, UNTYPED},
        {SET_HIGH,  1'b0, 24'hFFFFFF, UNTYPED},
        {SET_LOW,   1'b0, 24'h800000, UNTYPED},
        {SET_LOW,   1'b0, 24'h7FFFFF, UNTYPED},
        {SET_LOW,   1'b0, 24'h800000, UNTYPED},
        {SET_LOW,   1'b0, 24'h7FFFFF, UNTYPED},
        {SET_LOW,   1'b0, 24'h123456, UNTYPED},
        {SET_LOW,   1'b0, 24'hFEDCBA, UNTYPED}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // s_tdata: [23:0] input_sample
    logic [SMP_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // m_tdata: [31:0] filter_out, [33:32] dco_level, [65:34] dco_phase_next, zeros above
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Loop model: register copies and loop state
    logic [COEF_W-1:0]     pole_q, zero_now_q, zero_prev_q, centre_q, gain_q;
    logic [HALF_W-1:0]     half_q;
    longint                last_det, last_filt, phase_acc, level_now;

    pll_result_t           pending_results [$];
    int                    error_count     = 0;
    int                    clk_ticks       = 0;
    int                    ready_hold_left = 0;
    bit                    ready_hold_req  = 1'b0;
    bit                    no_idle         = 1'b0;

    digital_linear_pll_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run one sample through the loop model and advance its state
    function automatic pll_result_t advance_loop(input logic signed [SMP_W-1:0] sample);
        pll_result_t res;
        longint smp, det, a1, b0, b1, g, ci, hc, acc, filt, scaled, nxt;
        smp = sample;
        a1  = $signed(pole_q);
        b0  = $signed(zero_now_q);
        b1  = $signed(zero_prev_q);
        g   = $signed(gain_q);
        ci  = centre_q;
        hc  = half_q;
        det = smp * level_now;
        acc = -a1 * last_filt + b0 * det + b1 * last_det;
        filt = acc >>> FRAC_BITS;
        if (filt > FILT_MAX) filt = FILT_MAX;
        if (filt < FILT_MIN) filt = FILT_MIN;
        scaled = filt >>> DCO_SCALE_SHIFT;
        nxt = phase_acc + ci + g * scaled;
        // Wrap once by a full cycle, then fold into 32 bits
        if (nxt > hc) nxt = nxt - 2 * hc;
        nxt = longint'($signed(nxt[31:0]));
        res.filt  = filt[31:0];
        res.phase = nxt[31:0];
        if (level_now > 0)      res.level = LEVEL_POS;
        else if (level_now < 0) res.level = LEVEL_NEG;
        else                    res.level = LEVEL_ZERO;
        last_det  = det;
        last_filt = filt;
        phase_acc = nxt;
        level_now = (nxt >= 0) ? 1 : -1;
        return res;
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic send_sample(input logic [SMP_W-1:0] sample, input logic typed,
                               input pll_result_t typed_res);
        pll_result_t res;
        while (!no_idle && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        res = advance_loop(sample);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write one register; bits above its width carry random junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] word;
        word = $urandom;
        if (idx == REG_HALF_CYCLE) word[HALF_W-1:0] = value[HALF_W-1:0];
        else                       word[COEF_W-1:0] = value[COEF_W-1:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POLE_COEF:  pole_q      = word[COEF_W-1:0];
            REG_ZERO_NOW:   zero_now_q  = word[COEF_W-1:0];
            REG_ZERO_PREV:  zero_prev_q = word[COEF_W-1:0];
            REG_CENTRE_INC: centre_q    = word[COEF_W-1:0];
            REG_DCO_GAIN:   gain_q      = word[COEF_W-1:0];
            REG_HALF_CYCLE: half_q      = word[HALF_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] dflt);
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return dflt;
            5:       return 16'($urandom_range(16383)) - 16'd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 30'h3FFFFFFF;
            2:       return 30'd1;
            3, 4, 5: return HALF_CYCLE_RST;
            6:       return 30'($urandom);
            default: return 30'($urandom_range(200000, 1));
        endcase
    endfunction

    // Load a whole loop setting; the block must be idle
    task automatic apply_setting(input loop_setting_t which);
        case (which)
            SET_RESET: begin
                write_reg(REG_POLE_COEF,  32'(POLE_COEF_RST));
                write_reg(REG_ZERO_NOW,   32'(ZERO_NOW_RST));
                write_reg(REG_ZERO_PREV,  32'(ZERO_PREV_RST));
                write_reg(REG_CENTRE_INC, 32'(CENTRE_INC_RST));
                write_reg(REG_DCO_GAIN,   32'(DCO_GAIN_RST));
                write_reg(REG_HALF_CYCLE, 32'(HALF_CYCLE_RST));
            end
            SET_HIGH: begin
                write_reg(REG_POLE_COEF,  32'h8000);
                write_reg(REG_ZERO_NOW,   32'h7FFF);
                write_reg(REG_ZERO_PREV,  32'h7FFF);
                write_reg(REG_CENTRE_INC, 32'hFFFF);
                write_reg(REG_DCO_GAIN,   32'h7FFF);
                write_reg(REG_HALF_CYCLE, 32'h3FFFFFFF);
            end
            SET_LOW: begin
                write_reg(REG_SPARE_6,    32'hFFFFFFFF);
                write_reg(REG_POLE_COEF,  32'h7FFF);
                write_reg(REG_ZERO_NOW,   32'h8000);
                write_reg(REG_ZERO_PREV,  32'h8000);
                write_reg(REG_CENTRE_INC, 32'h0000);
                write_reg(REG_DCO_GAIN,   32'h8000);
                write_reg(REG_HALF_CYCLE, 32'h0);
                write_reg(REG_SPARE_7,    32'h0);
            end
            default: begin
                if ($urandom_range(3) == 0) write_reg(REG_SPARE_6, $urandom);
                write_reg(REG_POLE_COEF,  32'(pick_coef(POLE_COEF_RST)));
                write_reg(REG_ZERO_NOW,   32'(pick_coef(ZERO_NOW_RST)));
                write_reg(REG_ZERO_PREV,  32'(pick_coef(ZERO_PREV_RST)));
                write_reg(REG_CENTRE_INC, 32'(pick_coef(CENTRE_INC_RST)));
                write_reg(REG_DCO_GAIN,   32'(pick_coef(DCO_GAIN_RST)));
                write_reg(REG_HALF_CYCLE, 32'(pick_half()));
                if ($urandom_range(3) == 0) write_reg(REG_SPARE_7, $urandom);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Mostly full-range noise, plus small values, extremes and a square wave to track
    function automatic logic [SMP_W-1:0] pick_sample(input int n, input logic [SMP_W-1:0] amp);
        case ($urandom_range(19))
            0, 1, 2:     return 24'($urandom_range(511)) - 24'd256;
            3:           return 24'h7FFFFF;
            4:           return 24'h800000;
            5, 6, 7, 8:  return ((n / 8) % 2 != 0) ? amp : -amp;
            default:     return 24'($urandom);
        endcase
    endfunction

    function automatic void note_failure(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endfunction

    // Receiver: random stalls, or a long hold when the sender asks for one
    always @(posedge aclk) begin
        if (ready_hold_req) begin
            ready_hold_left = LONG_HOLD;
            ready_hold_req  = 1'b0;
        end
        if (ready_hold_left != 0) begin
            ready_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge aclk) begin : result_check
        pll_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.filt  = m_tdata[31:0];
            got.level = m_tdata[33:32];
            got.phase = m_tdata[65:34];
            if (pending_results.size() == 0) begin
                note_failure("result with no pending request", '0, got.phase);
            end else begin
                want = pending_results.pop_front();
                if (got.filt !== want.filt)   note_failure("filter_out", want.filt, got.filt);
                if (got.level !== want.level)
                    note_failure("dco_level", 32'(want.level), 32'(got.level));
                if (got.phase !== want.phase)
                    note_failure("dco_phase_next", want.phase, got.phase);
            end
        end
    end

    // Watchdog
    initial begin
        while (clk_ticks < CYCLE_LIMIT) begin
            @(posedge aclk);
            clk_ticks++;
        end
        $display("digital_linear_pll_core_tb failed");
        $finish;
    end

    initial begin : stimulus
        loop_setting_t     cur;
        logic [SMP_W-1:0]  amp;
        pole_q      = POLE_COEF_RST;
        zero_now_q  = ZERO_NOW_RST;
        zero_prev_q = ZERO_PREV_RST;
        centre_q    = CENTRE_INC_RST;
        gain_q      = DCO_GAIN_RST;
        half_q      = HALF_CYCLE_RST;
        last_det    = 0;
        last_filt   = 0;
        phase_acc   = 0;
        level_now   = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; reload the loop setting when a row asks for another
        cur = SET_RESET;
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].setting != cur) begin
                drain_results();
                cur = DIRECTED[i].setting;
                apply_setting(cur);
            end
            send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].result);
        end

        // Random phases, each under its own loop setting
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            no_idle = (ph == 2);
            apply_setting(ph == 0 ? SET_RESET : SET_RANDOM);
            amp = 24'($urandom);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Stall the receiver so the block backs up into its input
                if (ph == 3 && n == 40) ready_hold_req = 1'b1;
                // Pause the sender until the block has emptied
                if (ph == 4 && n == 100) drain_results();
                send_sample(pick_sample(n, amp), 1'b0, UNTYPED);
            end
        end

        drain_results();
        no_idle = 1'b0;
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("digital_linear_pll_core_tb passed");
        end else begin
            $display("digital_linear_pll_core_tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dlpll_pkg.sv
rtl/core/dlpll_datapath.sv
rtl/core/digital_linear_pll_core.sv
rtl/core/dlpll_checker.sv
tb/digital_linear_pll_core_tb.sv
